FILE: rtl/assert_macros.svh
// Assertion macros included by the top level of the button event queue.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The expression must hold at every clock edge outside reset.
`define ASSERT_ALWAYS(label, expr, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (expr)) else $error(msg);

// When the antecedent holds, the consequent must hold in the same cycle.
`define ASSERT_IMPLIES(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// When the antecedent holds, the consequent must hold in the following cycle.
`define ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: rtl/bphq_pkg.sv
// Types, constants and helper functions of the button press and hold event queue.
`timescale 1ns / 1ps

package bphq_pkg;

  localparam int unsigned PressLimit = 10;
  localparam int unsigned CfgIndexWidth = 2;
  localparam int unsigned CfgDataWidth = 16;

  // Configuration register indexes.
  localparam logic [CfgIndexWidth-1:0] CFG_DEBOUNCE    = 2'd0;
  localparam logic [CfgIndexWidth-1:0] CFG_HOLD_THRESH = 2'd1;
  localparam logic [CfgIndexWidth-1:0] CFG_LONG_GAP    = 2'd2;
  localparam logic [CfgIndexWidth-1:0] CFG_SINGLE      = 2'd3;

  // Commands carried by an input word.
  localparam logic CMD_POLL = 1'b0;
  localparam logic CMD_POP  = 1'b1;

  typedef enum logic [2:0] {
    EV_NONE       = 3'd0,
    EV_PREV_PRESS = 3'd1,
    EV_NEXT_PRESS = 3'd2,
    EV_PREV_HOLD  = 3'd3,
    EV_NEXT_HOLD  = 3'd4
  } event_code_e;

  typedef struct packed {
    logic [15:0] debounce_ms;
    logic [15:0] hold_threshold_ms;
    logic [15:0] long_gap_ms;
    logic        one_button;
  } cfg_t;

  localparam cfg_t CfgReset = '{
    debounce_ms:        16'd50,
    hold_threshold_ms:  16'd1000,
    long_gap_ms:        16'd500,
    one_button:         1'b0
  };

  typedef struct packed {
    logic        command;
    logic [31:0] now_ms;
    logic        prev_level_pressed;
    logic        next_level_pressed;
    logic [3:0]  prev_edge_count;
    logic [3:0]  next_edge_count;
  } item_t;

  // Per-button tracking state; the state holds one for prev and one for next.
  typedef struct packed {
    logic        was_down;
    logic        hold_fired;
    logic [31:0] press_start;
  } btn_t;

  typedef struct packed {
    logic [31:0] last_eval_time;
    btn_t        prev_btn;
    btn_t        next_btn;
    logic [3:0]  next_presses;
    logic [3:0]  prev_presses;
    event_code_e pending_hold;
  } state_t;

  localparam btn_t BtnReset = '{was_down: 1'b0, hold_fired: 1'b0, press_start: 32'd0};

  localparam state_t StateReset = '{
    last_eval_time: 32'd0,
    prev_btn:       BtnReset,
    next_btn:       BtnReset,
    next_presses:   4'd0,
    prev_presses:   4'd0,
    pending_hold:   EV_NONE
  };

  // Result of tracking one button over one evaluated poll.
  typedef struct packed {
    btn_t btn;
    logic hold;
    logic press;
  } btn_upd_t;

  // Adds to a press counter, saturating at the press limit.
  function automatic logic [3:0] sat_add(logic [3:0] cnt, logic [3:0] add);
    logic [4:0] sum;
    sum = {1'b0, cnt} + {1'b0, add};
    return (sum > 5'(PressLimit)) ? 4'(PressLimit) : sum[3:0];
  endfunction

  // One evaluated poll of one button: press start, hold detection, short release.
  function automatic btn_upd_t track_btn(btn_t cur, logic down, logic [31:0] now,
                                         logic [15:0] thresh);
    btn_upd_t   upd;
    logic [31:0] held;
    held = now - cur.press_start;
    upd.btn = cur;
    upd.hold = 1'b0;
    upd.press = 1'b0;
    if (down && !cur.was_down) begin
      upd.btn.press_start = now;
      upd.btn.hold_fired = 1'b0;
    end else if (down && cur.was_down) begin
      if (!cur.hold_fired && (held >= {16'd0, thresh})) begin
        upd.btn.hold_fired = 1'b1;
        upd.hold = 1'b1;
      end
    end else if (!down && cur.was_down) begin
      upd.press = !cur.hold_fired;
      upd.btn.hold_fired = 1'b0;
    end
    upd.btn.was_down = down;
    return upd;
  endfunction

endpackage

FILE: rtl/button_press_hold_event_queue_core.sv
// Top level of the button press and hold event queue: word registers, state and config.
`timescale 1ns / 1ps
//
//  Channel   Direction  Handshake                Payload
//  -------   ---------  -----------------------  ---------------------------------------
//  in        input      in_valid_i / in_ready_o  command, now_ms, levels, edge counts
//  out       output     out_valid_o / out_ready_i event_code, event_waiting
//  cfg       input      cfg_we_i (no wait)       cfg_index_i, cfg_wdata_i
//
//  One word is accepted per cycle when the output side keeps up; throughput is one
//  word per clock. The result word goes from the input word register through the
//  single evaluation stage into the result register; that stage also updates the
//  button state in the same cycle.
//  Reset (rst_ni low, asynchronous) empties both registers, clears the button state
//  and counters and loads the default configuration.
//  A stalled result holds the input word in its register; the input side then stays
//  ready only when the result is taken in the same cycle.

module button_press_hold_event_queue_core
  import bphq_pkg::*;
(
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     in_valid_i,
  output logic                     in_ready_o,
  input  logic                     command_i,
  input  logic [31:0]              now_ms_i,
  input  logic                     prev_level_pressed_i,
  input  logic                     next_level_pressed_i,
  input  logic [3:0]               prev_edge_count_i,
  input  logic [3:0]               next_edge_count_i,
  output logic                     out_valid_o,
  input  logic                     out_ready_i,
  output logic [2:0]               event_code_o,
  output logic                     event_waiting_o,
  input  logic                     cfg_we_i,
  input  logic [CfgIndexWidth-1:0] cfg_index_i,
  input  logic [CfgDataWidth-1:0]  cfg_wdata_i
);

`include "assert_macros.svh"

  cfg_t        cfg_q;
  item_t       item_q;
  logic        in_valid_q;
  state_t      state_q;
  state_t      state_d;
  event_code_e code_d;
  event_code_e code_q;
  logic        waiting_d;
  logic        waiting_q;
  logic        out_valid_q;
  logic        in_accept;
  logic        advance;

  // The held word moves on when the result register is empty or being drained.
  assign advance    = in_valid_q && (!out_valid_q || out_ready_i);
  assign in_ready_o = !in_valid_q || advance;
  assign in_accept  = in_valid_i && in_ready_o;

  // Configuration registers. The user must make writes only while the block is idle; the block does not enforce it.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= CfgReset;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        CFG_DEBOUNCE:    cfg_q.debounce_ms        <= cfg_wdata_i;
        CFG_HOLD_THRESH: cfg_q.hold_threshold_ms  <= cfg_wdata_i;
        CFG_LONG_GAP:    cfg_q.long_gap_ms        <= cfg_wdata_i;
        CFG_SINGLE:      cfg_q.one_button         <= cfg_wdata_i[0];
        default:         cfg_q                    <= cfg_q;
      endcase
    end
  end

  // Input word register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_accept) begin
      in_valid_q <= 1'b1;
    end else if (advance) begin
      in_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      item_q <= '{
        command:            command_i,
        now_ms:             now_ms_i,
        prev_level_pressed: prev_level_pressed_i,
        next_level_pressed: next_level_pressed_i,
        prev_edge_count:    prev_edge_count_i,
        next_edge_count:    next_edge_count_i
      };
    end
  end

  bphq_eval u_eval (
    .cfg_i     (cfg_q),
    .item_i    (item_q),
    .state_i   (state_q),
    .state_o   (state_d),
    .code_o    (code_d),
    .waiting_o (waiting_d)
  );

  // Button state and counters commit together with the result word.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StateReset;
      out_valid_q <= 1'b0;
    end else if (advance) begin
      state_q     <= state_d;
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      code_q    <= code_d;
      waiting_q <= waiting_d;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign event_code_o    = code_q;
  assign event_waiting_o = waiting_q;

  // Both press counters saturate at the press limit.
  `ASSERT_ALWAYS(a_counters_saturate,
      (state_q.next_presses <= 4'(PressLimit)) && (state_q.prev_presses <= 4'(PressLimit)),
      "press counter above limit")

  // Only a hold code or nothing can be pending.
  `ASSERT_ALWAYS(a_pending_is_hold,
      (state_q.pending_hold == EV_NONE) || (state_q.pending_hold == EV_PREV_HOLD) ||
      (state_q.pending_hold == EV_NEXT_HOLD), "pending hold holds a non-hold code")

  // A poll word always produces the empty event code.
  `ASSERT_NEXT(a_poll_gives_none, advance && (item_q.command == CMD_POLL),
      event_code_o == EV_NONE, "poll produced an event code")

  // In single-button mode the prev button tracking is frozen.
  `ASSERT_NEXT(a_single_freezes_prev, advance && cfg_q.one_button,
      $stable(state_q.prev_btn), "prev button state changed in single-button mode")

  // A word blocked by a stalled result stays in the input register.
  `ASSERT_NEXT(a_blocked_word_held, in_valid_q && !advance,
      in_valid_q && $stable(item_q), "blocked input word lost or changed")

endmodule

FILE: rtl/bphq_eval.sv
// Next-state and result logic for one poll or pop word of the button event queue.
`timescale 1ns / 1ps

module bphq_eval
  import bphq_pkg::*;
(
  input  cfg_t        cfg_i,
  input  item_t       item_i,
  input  state_t      state_i,
  output state_t      state_o,
  output event_code_e code_o,
  output logic        waiting_o
);

  logic [31:0] gap;
  logic        long_gap;
  logic        evaluate;
  btn_upd_t    prev_upd;
  btn_upd_t    next_upd;

  assign gap      = item_i.now_ms - state_i.last_eval_time;
  assign long_gap = gap > {16'd0, cfg_i.long_gap_ms};
  assign evaluate = gap >= {16'd0, cfg_i.debounce_ms};

  // A press that begins on a long-gap poll restarts its timing exactly as the
  // ordinary tracking does, so no separate restart path is needed.
  assign prev_upd = track_btn(state_i.prev_btn, item_i.prev_level_pressed, item_i.now_ms,
                              cfg_i.hold_threshold_ms);
  assign next_upd = track_btn(state_i.next_btn, item_i.next_level_pressed, item_i.now_ms,
                              cfg_i.hold_threshold_ms);

  always_comb begin
    state_o = state_i;
    code_o  = EV_NONE;
    if (item_i.command == CMD_POP) begin
      priority if (state_i.pending_hold != EV_NONE) begin
        code_o = state_i.pending_hold;
        state_o.pending_hold = EV_NONE;
      end else if (state_i.next_presses != 4'd0) begin
        code_o = EV_NEXT_PRESS;
        state_o.next_presses = state_i.next_presses - 4'd1;
      end else if (state_i.prev_presses != 4'd0) begin
        code_o = EV_PREV_PRESS;
        state_o.prev_presses = state_i.prev_presses - 4'd1;
      end else begin
        code_o = EV_NONE;
      end
    end else begin
      if (long_gap) begin
        if (!cfg_i.one_button) begin
          state_o.prev_presses = sat_add(state_i.prev_presses, item_i.prev_edge_count);
        end
        state_o.next_presses = sat_add(state_i.next_presses, item_i.next_edge_count);
      end
      if (evaluate) begin
        state_o.last_eval_time = item_i.now_ms;
        if (!cfg_i.one_button) begin
          state_o.prev_btn = prev_upd.btn;
          if (prev_upd.press) begin
            state_o.prev_presses = sat_add(state_o.prev_presses, 4'd1);
          end
          if (prev_upd.hold) begin
            state_o.pending_hold = EV_PREV_HOLD;
          end
        end
        state_o.next_btn = next_upd.btn;
        if (next_upd.press) begin
          state_o.next_presses = sat_add(state_o.next_presses, 4'd1);
        end
        if (next_upd.hold) begin
          state_o.pending_hold = EV_NEXT_HOLD;
        end
      end
    end
  end

  assign waiting_o = (state_o.next_presses != 4'd0) || (state_o.prev_presses != 4'd0) ||
                     (state_o.pending_hold != EV_NONE);

endmodule
